[hw/rtl/egs_pkg.sv]
// shared types, codes and sizes for the exclusion lattice gillespie step
// no dependencies; every other file of the block refers to it by scoped names
package egs_pkg;

    // lattice size default and fixed field widths
    localparam int SITES_DEFAULT = 32;
    localparam int SITE_W        = 6;
    localparam int CMD_W         = 2;
    localparam int INDEX_W       = 7;
    localparam int RATE_W        = 16;
    localparam int SUM_W         = 22;
    localparam int STATUS_W      = 2;
    localparam int COUNT_W       = 6;
    localparam int OP_W          = 2;

    // queue sizes between the parts
    localparam int CMDQ_DEPTH  = 4;
    localparam int CMDQ_PTR_W  = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_LVL_W  = $clog2(CMDQ_DEPTH + 1);
    localparam int OUTQ_DEPTH  = 4;
    localparam int OUTQ_PTR_W  = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_LVL_W  = $clog2(OUTQ_DEPTH + 1);

    // command codes on the input beat
    localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
    localparam logic [CMD_W-1:0] CMD_MOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_EMIT = 2'd2;

    // status codes on the result beat
    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RANGE   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BLOCKED = 2'd2;

    // classified operations handed from front to back
    localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
    localparam logic [OP_W-1:0] OP_MOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_EMIT = 2'd2;
    localparam logic [OP_W-1:0] OP_FAIL = 2'd3;

    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [INDEX_W-1:0] index;
        logic [RATE_W-1:0]  rate_value;
    } item_t;

    typedef struct packed {
        logic [INDEX_W-1:0]  entry_index;
        logic [SUM_W-1:0]    cumulative_rate;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  particle_total;
        logic                last;
    } result_t;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [INDEX_W-1:0] index;
        logic [RATE_W-1:0]  rate_value;
        logic [SITE_W-1:0]  src;
        logic [SITE_W-1:0]  dst;
        logic               has_src;
        logic               has_dst;
    } cmd_t;

endpackage

[hw/rtl/egs_front.sv]
// front end: accepts input beats, classifies each command, queues it for the back end
// depends on egs_pkg
module egs_front #(
    parameter int SITES = egs_pkg::SITES_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           full,
    input  egs_pkg::item_t item,
    output logic           cmd_valid,
    output egs_pkg::cmd_t  cmd,
    input  logic           cmd_pop
);

    localparam logic [egs_pkg::INDEX_W-1:0] LAST_SITE_IDX = egs_pkg::INDEX_W'(SITES);
    localparam logic [egs_pkg::INDEX_W-1:0] ENTER_R_IDX   = egs_pkg::INDEX_W'(SITES + 1);
    localparam logic [egs_pkg::INDEX_W-1:0] HOP_L_LAST    = egs_pkg::INDEX_W'(2 * SITES);
    localparam logic [egs_pkg::INDEX_W-1:0] TRANS_LAST    = egs_pkg::INDEX_W'(2 * SITES + 1);
    localparam logic [egs_pkg::INDEX_W-1:0] ONE_IDX       = egs_pkg::INDEX_W'(1);

    egs_pkg::cmd_t                  dec;
    logic [egs_pkg::INDEX_W-1:0]    hop_l_src;
    logic [egs_pkg::INDEX_W-1:0]    hop_r_src;
    egs_pkg::cmd_t                  q_mem [egs_pkg::CMDQ_DEPTH];
    logic [egs_pkg::CMDQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [egs_pkg::CMDQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [egs_pkg::CMDQ_LVL_W-1:0] level_reg, level_next;
    logic                           wr_en;

    // source sites of the hop moves
    assign hop_r_src = item.index - ONE_IDX;
    assign hop_l_src = TRANS_LAST - item.index;

    // classify the incoming command
    always_comb
    begin
        dec            = '0;
        dec.index      = item.index;
        dec.rate_value = item.rate_value;
        dec.op         = egs_pkg::OP_FAIL;
        case (item.command)
            egs_pkg::CMD_LOAD:
            begin
                if (item.index <= LAST_SITE_IDX)
                    dec.op = egs_pkg::OP_LOAD;
            end
            egs_pkg::CMD_MOVE:
            begin
                if (item.index <= TRANS_LAST)
                begin
                    dec.op = egs_pkg::OP_MOVE;
                    if (item.index == '0)
                    begin
                        // enter left
                        dec.dst     = '0;
                        dec.has_dst = 1'b1;
                    end
                    else if (item.index < LAST_SITE_IDX)
                    begin
                        // hop right
                        dec.src     = egs_pkg::SITE_W'(hop_r_src);
                        dec.dst     = egs_pkg::SITE_W'(item.index);
                        dec.has_src = 1'b1;
                        dec.has_dst = 1'b1;
                    end
                    else if (item.index == LAST_SITE_IDX)
                    begin
                        // exit right
                        dec.src     = egs_pkg::SITE_W'(SITES - 1);
                        dec.has_src = 1'b1;
                    end
                    else if (item.index == ENTER_R_IDX)
                    begin
                        // enter right
                        dec.dst     = egs_pkg::SITE_W'(SITES - 1);
                        dec.has_dst = 1'b1;
                    end
                    else if (item.index <= HOP_L_LAST)
                    begin
                        // hop left
                        dec.src     = egs_pkg::SITE_W'(hop_l_src);
                        dec.dst     = egs_pkg::SITE_W'(hop_l_src - ONE_IDX);
                        dec.has_src = 1'b1;
                        dec.has_dst = 1'b1;
                    end
                    else
                    begin
                        // exit left
                        dec.src     = '0;
                        dec.has_src = 1'b1;
                    end
                end
            end
            egs_pkg::CMD_EMIT:
            begin
                dec.op = egs_pkg::OP_EMIT;
            end
            default:
            begin
                dec.op = egs_pkg::OP_FAIL;
            end
        endcase
    end

    // command queue control
    assign full      = (level_reg == egs_pkg::CMDQ_LVL_W'(egs_pkg::CMDQ_DEPTH));
    assign cmd_valid = (level_reg != '0);
    assign cmd       = q_mem[rd_ptr_reg];
    assign wr_en     = push && !full;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (wr_en)
            wr_ptr_next = wr_ptr_reg + 1'b1;
        if (cmd_pop)
            rd_ptr_next = rd_ptr_reg + 1'b1;
        if (wr_en && !cmd_pop)
            level_next = level_reg + 1'b1;
        else if (!wr_en && cmd_pop)
            level_next = level_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
            q_mem[wr_ptr_reg] <= dec;
    end

endmodule

[hw/rtl/egs_back.sv]
// back end: lattice occupancy, particle count, rate memory and propensity accumulator
// depends on egs_pkg; pushes finished results into the result queue
module egs_back #(
    parameter int SITES = egs_pkg::SITES_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cmd_valid,
    input  egs_pkg::cmd_t                     cmd,
    output logic                              cmd_pop,
    input  logic [egs_pkg::OUTQ_LVL_W-1:0]    out_level,
    output logic                              res_push,
    output egs_pkg::result_t                  res
);

    localparam int AW    = $clog2(SITES + 1);
    localparam int EXT_W = SITES + 2;
    localparam logic [AW-1:0] K_LAST = AW'(SITES);
    localparam logic [egs_pkg::OUTQ_LVL_W:0] OUTQ_FULL_LVL =
        (egs_pkg::OUTQ_LVL_W + 1)'(egs_pkg::OUTQ_DEPTH);
    localparam logic [SITES-1:0] SITE_ONE = {{(SITES-1){1'b0}}, 1'b1};

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    typedef struct packed {
        logic                             emit;
        logic                             first;
        logic                             gate;
        logic                             last;
        logic [egs_pkg::INDEX_W-1:0]      index;
        logic [egs_pkg::STATUS_W-1:0]     status;
        logic [egs_pkg::COUNT_W-1:0]      total;
    } bstage_t;

    logic                          state_reg, state_next;
    logic [AW-1:0]                 k_reg, k_next;
    logic [SITES-1:0]              occ_reg, occ_next;
    logic [egs_pkg::COUNT_W-1:0]   count_reg, count_next;
    logic                          b_valid_reg, b_valid_next;
    bstage_t                       b_reg, b_next;
    logic [egs_pkg::RATE_W-1:0]    rate_mem [SITES+1];
    logic [egs_pkg::RATE_W-1:0]    rdata_reg;
    logic [egs_pkg::SUM_W-1:0]     sum_reg;
    logic                          mem_we;
    logic                          rd_en;
    logic [egs_pkg::OUTQ_LVL_W:0]  room_need;
    logic                          credit;
    logic [SITES-1:0]              src_shift, dst_shift;
    logic [SITES-1:0]              src_mask, dst_mask;
    logic                          blocked;
    logic [EXT_W-1:0]              ext, ext_shift;
    logic                          gate;
    logic [egs_pkg::SUM_W-1:0]     sum_base;
    logic [egs_pkg::RATE_W-1:0]    sum_add;
    logic [egs_pkg::SUM_W:0]       sum_wide;
    logic [egs_pkg::SUM_W-1:0]     sum_sat;

    // result queue space, counting the beat already in the output stage
    assign room_need = {1'b0, out_level} + (egs_pkg::OUTQ_LVL_W + 1)'(b_valid_reg);
    assign credit    = (room_need < OUTQ_FULL_LVL);

    // exclusion checks for a move
    assign src_shift = occ_reg >> cmd.src;
    assign dst_shift = occ_reg >> cmd.dst;
    assign src_mask  = SITE_ONE << cmd.src;
    assign dst_mask  = SITE_ONE << cmd.dst;
    assign blocked   = (cmd.has_src && !src_shift[0]) || (cmd.has_dst && dst_shift[0]);

    // gate for rate k: left neighbor occupied, right neighbor empty
    // reservoirs act as an occupied site on the left and an empty one on the right
    assign ext       = {1'b0, occ_reg, 1'b1};
    assign ext_shift = ext >> k_reg;
    assign gate      = ext_shift[0] && !ext_shift[1];

    // sequencer: single-beat commands and the propensity walk
    always_comb
    begin
        state_next   = state_reg;
        k_next       = k_reg;
        occ_next     = occ_reg;
        count_next   = count_reg;
        cmd_pop      = 1'b0;
        b_valid_next = 1'b0;
        b_next       = b_reg;
        mem_we       = 1'b0;
        rd_en        = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && (credit || cmd.op == egs_pkg::OP_EMIT))
                begin
                    cmd_pop      = 1'b1;
                    b_next.emit  = 1'b0;
                    b_next.first = 1'b0;
                    b_next.gate  = 1'b0;
                    b_next.last  = 1'b1;
                    b_next.index = cmd.index;
                    case (cmd.op)
                        egs_pkg::OP_LOAD:
                        begin
                            mem_we        = 1'b1;
                            b_valid_next  = 1'b1;
                            b_next.status = egs_pkg::STATUS_OK;
                            b_next.total  = count_reg;
                        end
                        egs_pkg::OP_MOVE:
                        begin
                            b_valid_next = 1'b1;
                            if (blocked)
                            begin
                                b_next.status = egs_pkg::STATUS_BLOCKED;
                            end
                            else
                            begin
                                b_next.status = egs_pkg::STATUS_OK;
                                if (cmd.has_src)
                                    occ_next = occ_next & ~src_mask;
                                if (cmd.has_dst)
                                    occ_next = occ_next | dst_mask;
                                if (cmd.has_src && !cmd.has_dst)
                                    count_next = count_reg - 1'b1;
                                else if (cmd.has_dst && !cmd.has_src)
                                    count_next = count_reg + 1'b1;
                            end
                            b_next.total = count_next;
                        end
                        egs_pkg::OP_EMIT:
                        begin
                            state_next = ST_EMIT;
                            k_next     = '0;
                        end
                        default:
                        begin
                            b_valid_next  = 1'b1;
                            b_next.status = egs_pkg::STATUS_RANGE;
                            b_next.total  = count_reg;
                        end
                    endcase
                end
            end
            ST_EMIT:
            begin
                if (credit)
                begin
                    rd_en         = 1'b1;
                    b_valid_next  = 1'b1;
                    b_next.emit   = 1'b1;
                    b_next.first  = (k_reg == '0);
                    b_next.gate   = gate;
                    b_next.last   = (k_reg == K_LAST);
                    b_next.index  = egs_pkg::INDEX_W'(k_reg);
                    b_next.status = egs_pkg::STATUS_OK;
                    b_next.total  = count_reg;
                    if (k_reg == K_LAST)
                        state_next = ST_IDLE;
                    else
                        k_next = k_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and lattice state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            k_reg       <= '0;
            occ_reg     <= '0;
            count_reg   <= '0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            k_reg       <= k_next;
            occ_reg     <= occ_next;
            count_reg   <= count_next;
            b_valid_reg <= b_valid_next;
        end
    end

    // rate memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            rate_mem[cmd.index[AW-1:0]] <= cmd.rate_value;
        if (rd_en)
            rdata_reg <= rate_mem[k_reg];
    end

    // running sum, saturated to the result width
    assign sum_base = b_reg.first ? '0 : sum_reg;
    assign sum_add  = b_reg.gate ? rdata_reg : '0;
    assign sum_wide = {1'b0, sum_base} + (egs_pkg::SUM_W + 1)'(sum_add);
    assign sum_sat  = sum_wide[egs_pkg::SUM_W] ? egs_pkg::SUM_MAX
                                               : sum_wide[egs_pkg::SUM_W-1:0];

    always_ff @(posedge clk)
    begin
        b_reg <= b_next;
        if (b_valid_reg && b_reg.emit)
            sum_reg <= sum_sat;
    end

    // output stage beat
    assign res_push              = b_valid_reg;
    assign res.entry_index       = b_reg.index;
    assign res.cumulative_rate   = b_reg.emit ? sum_sat : '0;
    assign res.status            = b_reg.status;
    assign res.particle_total    = b_reg.total;
    assign res.last              = b_reg.last;

endmodule

[hw/rtl/egs_outq.sv]
// result queue between the back end and the result port
// depends on egs_pkg
module egs_outq (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           res_push,
    input  egs_pkg::result_t               res,
    input  logic                           pop,
    output logic                           empty,
    output egs_pkg::result_t               result,
    output logic [egs_pkg::OUTQ_LVL_W-1:0] level
);

    egs_pkg::result_t               q_mem [egs_pkg::OUTQ_DEPTH];
    logic [egs_pkg::OUTQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [egs_pkg::OUTQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [egs_pkg::OUTQ_LVL_W-1:0] level_reg, level_next;
    logic                           rd_en;

    assign empty  = (level_reg == '0);
    assign level  = level_reg;
    assign result = q_mem[rd_ptr_reg];
    assign rd_en  = pop && !empty;

    // pointer and fill level update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (res_push)
            wr_ptr_next = wr_ptr_reg + 1'b1;
        if (rd_en)
            rd_ptr_next = rd_ptr_reg + 1'b1;
        if (res_push && !rd_en)
            level_next = level_reg + 1'b1;
        else if (!res_push && rd_en)
            level_next = level_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (res_push)
            q_mem[wr_ptr_reg] <= res;
    end

endmodule

[hw/rtl/exclusion_lattice_gillespie_step.sv]
// path of a load or transition result: command queue, back-end output stage, result queue
// throughput: one load or transition per cycle, or one rate of an emit walk over the rate memory
// (one read port) per cycle, while the result queue has room; the walk holds the back end
// reset: lattice empty, particle count zero, both queues empty; the rate memory is not cleared
module exclusion_lattice_gillespie_step #(
    parameter int SITES = egs_pkg::SITES_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  egs_pkg::item_t   item,
    output logic             empty,
    input  logic             pop,
    output egs_pkg::result_t result
);

    logic                           cmd_valid;
    egs_pkg::cmd_t                  cmd;
    logic                           cmd_pop;
    logic                           res_push;
    egs_pkg::result_t               res;
    logic [egs_pkg::OUTQ_LVL_W-1:0] out_level;

    // decode and command queue
    egs_front #(
        .SITES (SITES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    // lattice execution and propensity walk
    egs_back #(
        .SITES (SITES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .out_level (out_level),
        .res_push  (res_push),
        .res       (res)
    );

    // result queue
    egs_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res      (res),
        .pop      (pop),
        .empty    (empty),
        .result   (result),
        .level    (out_level)
    );

`ifndef SYNTHESIS
    // the back end never pushes into a full result queue
    a_outq_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> (out_level < egs_pkg::OUTQ_LVL_W'(egs_pkg::OUTQ_DEPTH)))
        else $error("result pushed into a full queue");

    // the back end only takes a command that is queued
    a_pop_has_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> cmd_valid)
        else $error("command taken from an empty queue");

    // an error result always closes its command
    a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.status != egs_pkg::STATUS_OK) |-> result.last)
        else $error("error result without last mark");
`endif

endmodule

[tb/tb_exclusion_lattice_gillespie_step.sv]
// self-checking testbench for exclusion_lattice_gillespie_step: lattice moves, rate loads, emits
// depends on egs_pkg for the beat structs and codes; carries its own lattice predictor
module tb_exclusion_lattice_gillespie_step;
    timeunit 1ns;
    timeprecision 1ps;

    import egs_pkg::*;

    localparam int P              = SITES_DEFAULT;
    localparam int LAST_MOVE      = 2 * P + 1;
    localparam int RANDOM_ITEMS   = 215;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 400;
    localparam int HOLD_AFTER     = 100;
    localparam int DRAIN_CYCLES   = 2 * P;

    // the package names no code for command 3, the block must still reject it
    localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    push = 1'b0;
    logic    pop = 1'b0;
    logic    full;
    logic    empty;
    item_t   item = '0;
    result_t result;

    // directed row: typed rows carry a hand-read single-beat answer
    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [INDEX_W-1:0]  idx;
        logic [RATE_W-1:0]   val;
        bit                  typed;
        logic [STATUS_W-1:0] st;
        logic [COUNT_W-1:0]  cnt;
    } probe_row_t;

    probe_row_t probe_rows [0:24] = '{
        '{CMD_MOVE,    7'd0,   16'h0000, 1'b1, STATUS_OK,      6'd1},
        '{CMD_MOVE,    7'd0,   16'hFFFF, 1'b1, STATUS_BLOCKED, 6'd1},
        '{CMD_MOVE,    7'd65,  16'h0000, 1'b1, STATUS_OK,      6'd0},
        '{CMD_MOVE,    7'd65,  16'h0000, 1'b1, STATUS_BLOCKED, 6'd0},
        '{CMD_MOVE,    7'd66,  16'h0000, 1'b1, STATUS_RANGE,   6'd0},
        '{CMD_MOVE,    7'd127, 16'hFFFF, 1'b1, STATUS_RANGE,   6'd0},
        '{CMD_MOVE,    7'd32,  16'h0000, 1'b1, STATUS_BLOCKED, 6'd0},
        '{CMD_MOVE,    7'd1,   16'h0000, 1'b1, STATUS_BLOCKED, 6'd0},
        '{CMD_LOAD,    7'd33,  16'hFFFF, 1'b1, STATUS_RANGE,   6'd0},
        '{CMD_LOAD,    7'd127, 16'h1234, 1'b1, STATUS_RANGE,   6'd0},
        '{CMD_UNKNOWN, 7'd5,   16'h0000, 1'b1, STATUS_RANGE,   6'd0},
        '{CMD_UNKNOWN, 7'd127, 16'hFFFF, 1'b1, STATUS_RANGE,   6'd0},
        '{CMD_LOAD,    7'd0,   16'hFFFF, 1'b1, STATUS_OK,      6'd0},
        '{CMD_LOAD,    7'd32,  16'hFFFF, 1'b1, STATUS_OK,      6'd0},
        '{CMD_EMIT,    7'd127, 16'h0000, 1'b0, STATUS_OK,      6'd0},
        '{CMD_MOVE,    7'd33,  16'h0000, 1'b1, STATUS_OK,      6'd1},
        '{CMD_MOVE,    7'd33,  16'h0000, 1'b1, STATUS_BLOCKED, 6'd1},
        '{CMD_MOVE,    7'd34,  16'h0000, 1'b1, STATUS_OK,      6'd1},
        '{CMD_MOVE,    7'd31,  16'h0000, 1'b1, STATUS_OK,      6'd1},
        '{CMD_MOVE,    7'd0,   16'h0000, 1'b1, STATUS_OK,      6'd2},
        '{CMD_MOVE,    7'd1,   16'h0000, 1'b1, STATUS_OK,      6'd2},
        '{CMD_MOVE,    7'd64,  16'h0000, 1'b1, STATUS_OK,      6'd2},
        '{CMD_EMIT,    7'd0,   16'hFFFF, 1'b0, STATUS_OK,      6'd0},
        '{CMD_MOVE,    7'd32,  16'h0000, 1'b1, STATUS_OK,      6'd1},
        '{CMD_LOAD,    7'd16,  16'h0000, 1'b1, STATUS_OK,      6'd1}
    };

    // predictor state
    bit [P-1:0]         occ_model;
    logic [COUNT_W-1:0] count_model;
    logic [RATE_W-1:0]  rates_model [0:P];

    result_t predicted_beats [$];
    result_t pending_results [$];
    int      mismatch_count = 0;
    int      beats_popped = 0;
    int      idle_cycles = 0;
    int      burst_left = 0;

    exclusion_lattice_gillespie_step #(
        .SITES(P)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .item(item),
        .empty(empty),
        .pop(pop),
        .result(result)
    );

    always #2 clk = ~clk;

    // try transition j on the predicted lattice, commit only when asked and legal
    function automatic logic [STATUS_W-1:0] lattice_move(input int j, input bit commit);
        int src;
        int dst;
        bit hs;
        bit hd;
        src = 0;
        dst = 0;
        hs = 1'b0;
        hd = 1'b0;
        if (j > LAST_MOVE)
            return STATUS_RANGE;
        if (j == 0)
        begin
            dst = 0;
            hd = 1'b1;
        end
        else if (j < P)
        begin
            src = j - 1;
            dst = j;
            hs = 1'b1;
            hd = 1'b1;
        end
        else if (j == P)
        begin
            src = P - 1;
            hs = 1'b1;
        end
        else if (j == P + 1)
        begin
            dst = P - 1;
            hd = 1'b1;
        end
        else if (j <= 2 * P)
        begin
            src = LAST_MOVE - j;
            dst = src - 1;
            hs = 1'b1;
            hd = 1'b1;
        end
        else
        begin
            src = 0;
            hs = 1'b1;
        end
        if (hs && !occ_model[src])
            return STATUS_BLOCKED;
        if (hd && occ_model[dst])
            return STATUS_BLOCKED;
        if (commit)
        begin
            if (hs)
                occ_model[src] = 1'b0;
            if (hd)
                occ_model[dst] = 1'b1;
            if (hs && !hd)
                count_model = count_model - 1'b1;
            if (hd && !hs)
                count_model = count_model + 1'b1;
        end
        return STATUS_OK;
    endfunction

    // advance the predicted lattice by one command and list the beats it yields
    function automatic void lattice_predict(input item_t it);
        result_t r;
        int unsigned sum;
        bit gate;
        predicted_beats.delete();
        r = '0;
        r.entry_index = it.index;
        r.last = 1'b1;
        case (it.command)
            CMD_LOAD:
            begin
                r.status = STATUS_RANGE;
                if (it.index <= P)
                begin
                    rates_model[it.index] = it.rate_value;
                    r.status = STATUS_OK;
                end
                r.particle_total = count_model;
                predicted_beats.push_back(r);
            end
            CMD_MOVE:
            begin
                r.status = lattice_move(int'(it.index), 1'b1);
                r.particle_total = count_model;
                predicted_beats.push_back(r);
            end
            CMD_EMIT:
            begin
                sum = 0;
                for (int k = 0; k <= P; k++)
                begin
                    if (k == 0)
                        gate = !occ_model[0];
                    else if (k < P)
                        gate = occ_model[k-1] && !occ_model[k];
                    else
                        gate = occ_model[P-1];
                    if (gate)
                    begin
                        sum += rates_model[k];
                        if (sum > SUM_MAX)
                            sum = SUM_MAX;
                    end
                    r.entry_index = k[INDEX_W-1:0];
                    r.cumulative_rate = sum[SUM_W-1:0];
                    r.status = STATUS_OK;
                    r.particle_total = count_model;
                    r.last = (k == P);
                    predicted_beats.push_back(r);
                end
            end
            default:
            begin
                r.status = STATUS_RANGE;
                r.particle_total = count_model;
                predicted_beats.push_back(r);
            end
        endcase
    endfunction

    // one input beat: burst/gap shaping, wait for acceptance, then queue the answer
    task automatic offer(input item_t it, input bit typed, input result_t typed_res);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            if ($urandom_range(0, 3) != 0)
            begin
                gap = $urandom_range(1, 10);
                repeat (gap) @(negedge clk) push <= 1'b0;
            end
        end
        burst_left--;
        @(negedge clk);
        push <= 1'b1;
        item <= it;
        @(posedge clk);
        while (full)
            @(posedge clk);
        lattice_predict(it);
        if (typed)
            pending_results.push_back(typed_res);
        else
            foreach (predicted_beats[i])
                pending_results.push_back(predicted_beats[i]);
    endtask

    // compare one popped beat with the oldest expectation
    task automatic check_beat(input result_t got);
        result_t want;
        beats_popped++;
        if (pending_results.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("unexpected beat: idx=%0d sum=%0d st=%0d cnt=%0d last=%0d",
                         got.entry_index, got.cumulative_rate, got.status,
                         got.particle_total, got.last);
        end
        else
        begin
            want = pending_results.pop_front();
            if (got.entry_index !== want.entry_index
                || got.cumulative_rate !== want.cumulative_rate
                || got.status !== want.status
                || got.particle_total !== want.particle_total
                || got.last !== want.last)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                begin
                    $display("mismatch: want idx=%0d sum=%0d st=%0d cnt=%0d last=%0d",
                             want.entry_index, want.cumulative_rate, want.status,
                             want.particle_total, want.last);
                    $display("          got  idx=%0d sum=%0d st=%0d cnt=%0d last=%0d",
                             got.entry_index, got.cumulative_rate, got.status,
                             got.particle_total, got.last);
                end
            end
        end
    endtask

    // receiver: pop pattern changes at random intervals, plus one long hold-off
    initial
    begin
        int mode;
        int mode_left;
        int hold_left;
        int tick;
        bit held;
        mode = 0;
        mode_left = 0;
        hold_left = 0;
        tick = 0;
        held = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (!held && beats_popped >= HOLD_AFTER)
            begin
                held = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (mode_left == 0)
            begin
                mode = $urandom_range(0, 3);
                mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            tick++;
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
            begin
                case (mode)
                    0: pop <= 1'b1;
                    1: pop <= 1'($urandom_range(0, 1));
                    2: pop <= (tick % 5 == 0);
                    default: pop <= ($urandom_range(0, 3) != 0);
                endcase
            end
            @(posedge clk);
            if (pop && !empty)
                check_beat(result);
        end
    end

    // watchdog on cycles with no beat moving on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                idle_cycles <= 0;
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // stimulus
    initial
    begin
        item_t   it;
        result_t typed_res;
        int      j;
        int      tries;
        int      pick;
        occ_model = '0;
        count_model = '0;
        repeat (3) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        // preload every rate so no emit ever reads an unwritten entry
        for (int k = 0; k <= P; k++)
        begin
            it.command = CMD_LOAD;
            it.index = k[INDEX_W-1:0];
            if (k == 1)
                it.rate_value = 16'hFFFF;
            else if (k == 2)
                it.rate_value = 16'h0000;
            else
                it.rate_value = RATE_W'($urandom_range(0, 65535));
            offer(it, 1'b0, '0);
        end

        // directed rows: range and blocked cases, all six move kinds, emits
        foreach (probe_rows[n])
        begin
            it.command = probe_rows[n].cmd;
            it.index = probe_rows[n].idx;
            it.rate_value = probe_rows[n].val;
            typed_res = '0;
            typed_res.entry_index = probe_rows[n].idx;
            typed_res.status = probe_rows[n].st;
            typed_res.particle_total = probe_rows[n].cnt;
            typed_res.last = 1'b1;
            offer(it, probe_rows[n].typed, typed_res);
        end

        // random part: mostly legal moves, some emits and loads, a little noise
        repeat (RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            it.index = INDEX_W'($urandom);
            it.rate_value = RATE_W'($urandom);
            if (pick < 60)
            begin
                it.command = CMD_MOVE;
                tries = 0;
                do
                begin
                    j = $urandom_range(0, LAST_MOVE);
                    tries++;
                end
                while (lattice_move(j, 1'b0) != STATUS_OK && tries < 4);
                it.index = j[INDEX_W-1:0];
            end
            else if (pick < 72)
                it.command = CMD_EMIT;
            else if (pick < 85)
            begin
                it.command = CMD_LOAD;
                it.index = INDEX_W'($urandom_range(0, P));
            end
            else if (pick < 90)
            begin
                it.command = CMD_LOAD;
                it.index = INDEX_W'($urandom_range(P + 1, 127));
            end
            else if (pick < 95)
            begin
                it.command = CMD_MOVE;
                it.index = INDEX_W'($urandom_range(LAST_MOVE + 1, 127));
            end
            else
                it.command = CMD_UNKNOWN;
            offer(it, 1'b0, '0);
        end
        @(negedge clk) push <= 1'b0;

        // drain, then give stray beats a chance to show up
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/egs_pkg.sv
hw/rtl/egs_front.sv
hw/rtl/egs_back.sv
hw/rtl/egs_outq.sv
hw/rtl/exclusion_lattice_gillespie_step.sv
tb/tb_exclusion_lattice_gillespie_step.sv
